// ===== rtl/rbs_pkg.sv =====
// shared types, constants and arithmetic helpers for the ray/box slab test
package rbs_pkg;

    localparam int NUM_REGS        = 6;
    localparam int ADDR_W          = 5;
    localparam int DIV_STEPS       = 33;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

    localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic [31:0] BOX_MIN_RESET = 32'hFFFF_0000;
    localparam logic [31:0] BOX_MAX_RESET = 32'h0001_0000;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    localparam logic [2:0] FACE_NEG_X = 3'd0;
    localparam logic [2:0] FACE_POS_X = 3'd1;
    localparam logic [2:0] FACE_NEG_Y = 3'd2;
    localparam logic [2:0] FACE_POS_Y = 3'd3;
    localparam logic [2:0] FACE_NEG_Z = 3'd4;
    localparam logic [2:0] FACE_POS_Z = 3'd5;

    localparam logic [2:0][2:0] FACE_LO = {FACE_NEG_Z, FACE_NEG_Y, FACE_NEG_X};
    localparam logic [2:0][2:0] FACE_HI = {FACE_POS_Z, FACE_POS_Y, FACE_POS_X};

    typedef struct packed {
        logic [2:0][31:0] origin;
        logic [2:0][31:0] dir;
        logic [31:0]      limit;
    } ray_t;

    typedef struct packed {
        logic [2:0][31:0] rem;
        logic [2:0][31:0] quo;
        logic [2:0][31:0] dmag;
    } div_t;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] d,
                                             input logic b);
        logic [32:0] t;
        logic [32:0] r;
        t = {rem, b};
        if (t >= {1'b0, d})
            r = {1'b1, 32'(t - {1'b0, d})};
        else
            r = {1'b0, t[31:0]};
        return r;
    endfunction

    // floor by 2^16 then clamp to the signed 32-bit range
    function automatic logic [31:0] sat_floor(input logic signed [64:0] p);
        logic signed [48:0] f;
        logic [31:0] r;
        f = 49'(p >>> 16);
        if (f > 49'(Q_MAX))
            r = Q_MAX;
        else if (f < 49'(Q_MIN))
            r = Q_MIN;
        else
            r = f[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/ray_box_slab_intersection.sv =====
// top level: box corner registers, apb port and the slab test pipeline
//
// One ray per clock is taken while the result side keeps up. Each ray
// passes the reciprocal divider (three restoring steps per stage over 33
// quotient bits), then the stages that form the plane distances around the
// 33x32 multipliers, and then those that pick near/far, entry/exit and the
// hit. The whole pipeline holds as one when a result waits and out_ready is
// low. Box corners are six signed Q16.16 registers at byte addresses 0 to 20
// and should be written only while no ray is in flight.
module ray_box_slab_intersection (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [31:0]          origin_x,
    input  logic signed [31:0]          origin_y,
    input  logic signed [31:0]          origin_z,
    input  logic signed [31:0]          dir_x,
    input  logic signed [31:0]          dir_y,
    input  logic signed [31:0]          dir_z,
    input  logic signed [31:0]          distance_limit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic signed [31:0]          hit_distance,
    output logic [2:0]                  hit_face
);

    logic [rbs_pkg::NUM_REGS-1:0][31:0] box_reg;
    logic [2:0]                         reg_idx;
    logic                               adv;
    rbs_pkg::ray_t                      ray_in, ray_r;
    logic                               v_recip, v_plane;
    logic [2:0][31:0]                   recip;
    logic [2:0][31:0]                   t_lo, t_hi;
    logic [31:0]                        limit;
    logic [31:0]                        sel_dist;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg[rbs_pkg::REG_BOX_MIN_X] <= rbs_pkg::BOX_MIN_RESET;
            box_reg[rbs_pkg::REG_BOX_MIN_Y] <= rbs_pkg::BOX_MIN_RESET;
            box_reg[rbs_pkg::REG_BOX_MIN_Z] <= rbs_pkg::BOX_MIN_RESET;
            box_reg[rbs_pkg::REG_BOX_MAX_X] <= rbs_pkg::BOX_MAX_RESET;
            box_reg[rbs_pkg::REG_BOX_MAX_Y] <= rbs_pkg::BOX_MAX_RESET;
            box_reg[rbs_pkg::REG_BOX_MAX_Z] <= rbs_pkg::BOX_MAX_RESET;
        end
        else if (psel && penable && pwrite && (32'(reg_idx) < rbs_pkg::NUM_REGS))
        begin
            box_reg[reg_idx] <= pwdata;
        end
    end

    always_comb
    begin
        if (32'(reg_idx) < rbs_pkg::NUM_REGS)
            prdata = box_reg[reg_idx];
        else
            prdata = 32'd0;
    end

    // the pipeline moves whenever the output stage is empty or being taken
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign ray_in.origin = {origin_z, origin_y, origin_x};
    assign ray_in.dir    = {dir_z, dir_y, dir_x};
    assign ray_in.limit  = distance_limit;

    rbs_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .ray       (ray_in),
        .out_valid (v_recip),
        .ray_out   (ray_r),
        .recip     (recip)
    );

    rbs_plane u_plane (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v_recip),
        .ray       (ray_r),
        .recip     (recip),
        .box_lo    ({box_reg[rbs_pkg::REG_BOX_MIN_Z], box_reg[rbs_pkg::REG_BOX_MIN_Y],
                     box_reg[rbs_pkg::REG_BOX_MIN_X]}),
        .box_hi    ({box_reg[rbs_pkg::REG_BOX_MAX_Z], box_reg[rbs_pkg::REG_BOX_MAX_Y],
                     box_reg[rbs_pkg::REG_BOX_MAX_X]}),
        .out_valid (v_plane),
        .t_lo      (t_lo),
        .t_hi      (t_hi),
        .limit     (limit)
    );

    rbs_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (v_plane),
        .t_lo         (t_lo),
        .t_hi         (t_hi),
        .limit        (limit),
        .out_valid    (out_valid),
        .hit          (hit),
        .hit_distance (sel_dist),
        .hit_face     (hit_face)
    );

    assign hit_distance = $signed(sel_dist);

endmodule

// ===== rtl/rbs_recip.sv =====
// pipelined reciprocal of the three direction components, 2^32 / d saturated
module rbs_recip (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  rbs_pkg::ray_t       ray,
    output logic                out_valid,
    output rbs_pkg::ray_t       ray_out,
    output logic [2:0][31:0]    recip
);

    localparam int NS = rbs_pkg::DIV_STAGES;

    logic [NS:0]       valid_reg;
    rbs_pkg::ray_t     ray_reg [0:NS];
    rbs_pkg::div_t     div_reg [0:NS];
    rbs_pkg::div_t     div_next [0:NS];
    rbs_pkg::div_t     div_first;

    logic              valid_o_reg;
    rbs_pkg::ray_t     ray_o_reg;
    logic [2:0][31:0]  recip_reg;
    logic [2:0][31:0]  recip_next;

    // magnitude of each component, remainder and quotient start at zero
    always_comb
    begin
        div_first = '0;
        for (int a = 0; a < 3; a++)
        begin
            div_first.dmag[a] = ray.dir[a][31] ? 32'(-ray.dir[a]) : ray.dir[a];
        end
    end

    // three long-division steps per stage; the dividend has only bit 32 set
    always_comb
    begin
        logic [32:0] r;
        div_next[0] = div_first;
        for (int k = 1; k <= NS; k++)
        begin
            div_next[k] = div_reg[k-1];
            for (int j = 0; j < rbs_pkg::STEPS_PER_STAGE; j++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    r = rbs_pkg::div_step(div_next[k].rem[a], div_next[k].dmag[a],
                                          (k == 1) && (j == 0));
                    div_next[k].rem[a] = r[31:0];
                    div_next[k].quo[a] = {div_next[k].quo[a][30:0], r[32]};
                end
            end
        end
    end

    // magnitudes of one or two overflow the Q16.16 range
    always_comb
    begin
        logic small_mag;
        for (int a = 0; a < 3; a++)
        begin
            small_mag = div_reg[NS].dmag[a] <= 32'd2;
            if (ray_reg[NS].dir[a] == 32'd0)
                recip_next[a] = rbs_pkg::Q_MAX;
            else if (!ray_reg[NS].dir[a][31])
                recip_next[a] = small_mag ? rbs_pkg::Q_MAX : div_reg[NS].quo[a];
            else
                recip_next[a] = small_mag ? rbs_pkg::Q_MIN : 32'(-div_reg[NS].quo[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_o_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg   <= {valid_reg[NS-1:0], in_valid};
            valid_o_reg <= valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray_reg[0] <= ray;
            for (int k = 0; k <= NS; k++)
                div_reg[k] <= div_next[k];
            for (int k = 1; k <= NS; k++)
                ray_reg[k] <= ray_reg[k-1];
            ray_o_reg <= ray_reg[NS];
            recip_reg <= recip_next;
        end
    end

    assign out_valid = valid_o_reg;
    assign ray_out   = ray_o_reg;
    assign recip     = recip_reg;

endmodule

// ===== rtl/rbs_plane.sv =====
// six plane distances: corner minus origin, times reciprocal, floor and clamp
module rbs_plane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  rbs_pkg::ray_t       ray,
    input  logic [2:0][31:0]    recip,
    input  logic [2:0][31:0]    box_lo,
    input  logic [2:0][31:0]    box_hi,
    output logic                out_valid,
    output logic [2:0][31:0]    t_lo,
    output logic [2:0][31:0]    t_hi,
    output logic [31:0]         limit
);

    logic [2:0]        valid_reg;
    logic [2:0][32:0]  dlo_reg, dhi_reg, dlo_next, dhi_next;
    logic [2:0][31:0]  rcp_reg;
    logic [2:0][64:0]  plo_reg, phi_reg, plo_next, phi_next;
    logic [2:0][31:0]  tlo_reg, thi_reg, tlo_next, thi_next;
    logic [31:0]       lim_a_reg, lim_b_reg, lim_c_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dlo_next[a] = {box_lo[a][31], box_lo[a]} - {ray.origin[a][31], ray.origin[a]};
            dhi_next[a] = {box_hi[a][31], box_hi[a]} - {ray.origin[a][31], ray.origin[a]};
            plo_next[a] = 65'($signed(dlo_reg[a])) * 65'($signed(rcp_reg[a]));
            phi_next[a] = 65'($signed(dhi_reg[a])) * 65'($signed(rcp_reg[a]));
            tlo_next[a] = rbs_pkg::sat_floor($signed(plo_reg[a]));
            thi_next[a] = rbs_pkg::sat_floor($signed(phi_reg[a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlo_reg   <= dlo_next;
            dhi_reg   <= dhi_next;
            rcp_reg   <= recip;
            lim_a_reg <= ray.limit;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            lim_b_reg <= lim_a_reg;
            tlo_reg   <= tlo_next;
            thi_reg   <= thi_next;
            lim_c_reg <= lim_b_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign t_lo      = tlo_reg;
    assign t_hi      = thi_reg;
    assign limit     = lim_c_reg;

endmodule

// ===== rtl/rbs_select.sv =====
// near/far per axis, entry/exit across axes, and the hit decision
module rbs_select (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [2:0][31:0]    t_lo,
    input  logic [2:0][31:0]    t_hi,
    input  logic [31:0]         limit,
    output logic                out_valid,
    output logic                hit,
    output logic [31:0]         hit_distance,
    output logic [2:0]          hit_face
);

    logic [2:0]        valid_reg;
    logic [2:0][31:0]  near_reg, far_reg, near_next, far_next;
    logic [2:0][2:0]   nface_reg, nface_next;
    logic [31:0]       lim_d_reg, lim_e_reg;
    logic [31:0]       entry_reg, exit_reg, entry_next, exit_next;
    logic [2:0]        face_reg, face_next;
    logic              hit_reg, hit_next;
    logic [31:0]       dist_reg, dist_next;
    logic [2:0]        hface_reg, hface_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(t_lo[a]) < $signed(t_hi[a]))
            begin
                near_next[a]  = t_lo[a];
                far_next[a]   = t_hi[a];
                nface_next[a] = rbs_pkg::FACE_LO[a];
            end
            else
            begin
                near_next[a]  = t_hi[a];
                far_next[a]   = t_lo[a];
                nface_next[a] = rbs_pkg::FACE_HI[a];
            end
        end
    end

    // ties between x and y go to y; z must be strictly larger
    always_comb
    begin
        if ($signed(near_reg[0]) > $signed(near_reg[1]))
        begin
            entry_next = near_reg[0];
            face_next  = nface_reg[0];
        end
        else
        begin
            entry_next = near_reg[1];
            face_next  = nface_reg[1];
        end
        if ($signed(near_reg[2]) > $signed(entry_next))
        begin
            entry_next = near_reg[2];
            face_next  = nface_reg[2];
        end
        exit_next = far_reg[0];
        if ($signed(far_reg[1]) < $signed(exit_next))
            exit_next = far_reg[1];
        if ($signed(far_reg[2]) < $signed(exit_next))
            exit_next = far_reg[2];
    end

    // origin inside the box reports the exit distance
    always_comb
    begin
        logic [31:0] first;
        first = entry_reg[31] ? exit_reg : entry_reg;
        hit_next = !exit_reg[31] && !($signed(entry_reg) > $signed(exit_reg))
                   && !($signed(first) > $signed(lim_e_reg));
        dist_next  = hit_next ? first : 32'd0;
        hface_next = hit_next ? face_reg : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            near_reg  <= near_next;
            far_reg   <= far_next;
            nface_reg <= nface_next;
            lim_d_reg <= limit;
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
            face_reg  <= face_next;
            lim_e_reg <= lim_d_reg;
            hit_reg   <= hit_next;
            dist_reg  <= dist_next;
            hface_reg <= hface_next;
        end
    end

    assign out_valid    = valid_reg[2];
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign hit_face     = hface_reg;

endmodule

// ===== rtl/rbs_checker.sv =====
// port-level checks for the slab test block, bound to the top level
module rbs_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [31:0]          origin_x,
    input  logic signed [31:0]          origin_y,
    input  logic signed [31:0]          origin_z,
    input  logic signed [31:0]          dir_x,
    input  logic signed [31:0]          dir_y,
    input  logic signed [31:0]          dir_z,
    input  logic signed [31:0]          distance_limit,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        hit,
    input  logic signed [31:0]          hit_distance,
    input  logic [2:0]                  hit_face
);

    // a stalled result keeps out_valid, distance and face until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_distance) && $stable(hit_face))
        else $error("result changed while stalled");

    // a miss reports zero distance and face
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == 32'sd0 && hit_face == 3'd0)
        else $error("miss with nonzero fields");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> hit_face <= 3'd5)
        else $error("face code out of range");

    // an empty output stage never blocks the input side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind ray_box_slab_intersection rbs_checker u_rbs_checker (.*);
